@@ rtl/dda_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the DDA line rasterizer.
// Used by dda_divider and dda_line_rasterizer_core; depends on nothing.
package dda_pkg;

  // Fixed widths of the interface fields.
  localparam int COORD_W   = 21;
  localparam int LIMIT_W   = 13;
  localparam int COLOUR_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1024;

  // Input item actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Main sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DELTA = 5'b00010,
    S_COUNT = 5'b00100,
    S_DIVX  = 5'b01000,
    S_DIVY  = 5'b10000
  } state_t;

  // Status reported by the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/dda_divider.sv @@
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on dda_pkg for its status struct.
module dda_divider #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output dda_pkg::div_stat_t   stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVD_W-1:0]   quo_r;
  logic [DVS_W-1:0]   dvs_r;

  logic [DVS_W:0]     shifted;
  logic [DVS_W+1:0]   diff;
  logic               fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/dda_line_rasterizer_core.sv @@
`timescale 1ns / 1ps
// Top level of the DDA line rasterizer: load sequencer, stepping datapath,
// bounds registers and output register. Depends on dda_pkg and dda_divider.
//
// Usage: every transfer on the input channel returns exactly one transfer on
// the output channel. A load item (action 0) sets up a line from its start
// and end points and colour; a step item (action 1) returns the current
// pixel and advances along the line. line_done is 1 once the line is over,
// or on any step while no line is active.
// Load sequence: capture the item, form the deltas, find the step count,
// then run two passes of the shared divider, the x increment first and
// then the y increment. A line with a zero step count skips the divider
// and returns its result once the step count is found.
// Step items can follow back to back while the output is not stalled,
// set by the single add-and-compare stage that advances the position.
// The output register holds one result; while it is full and out_stall is
// high the block stalls its input. Configuration writes land at once and
// should only be issued while the block is idle.
// Reset (synchronous, active low) clears the sequencer, the active line and
// the output register, and sets both limits to 1024.
module dda_line_rasterizer_core #(
  parameter int COORD_INT_BITS = 12,
  parameter int IN_FRAC_BITS   = 8,
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_wen,
  input  logic [dda_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dda_pkg::LIMIT_W-1:0]           cfg_wdata,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic signed [dda_pkg::COORD_W-1:0]    in_x_start,
  input  logic signed [dda_pkg::COORD_W-1:0]    in_y_start,
  input  logic signed [dda_pkg::COORD_W-1:0]    in_x_end,
  input  logic signed [dda_pkg::COORD_W-1:0]    in_y_end,
  input  logic [dda_pkg::COLOUR_W-1:0]          in_colour,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [COORD_INT_BITS-1:0]             out_pixel_x,
  output logic [COORD_INT_BITS-1:0]             out_pixel_y,
  output logic [dda_pkg::COLOUR_W-1:0]          out_pixel_colour,
  output logic                                  out_pixel_valid,
  output logic                                  out_line_done
);

  localparam int COORD_W = dda_pkg::COORD_W;
  localparam int LIMIT_W = dda_pkg::LIMIT_W;
  localparam int S       = STEP_FRAC_BITS;
  localparam int C       = COORD_INT_BITS;

  // Scaling between input and step formats: one of these is zero.
  localparam int UP = (STEP_FRAC_BITS >= IN_FRAC_BITS) ? STEP_FRAC_BITS - IN_FRAC_BITS : 0;
  localparam int DN = (IN_FRAC_BITS > STEP_FRAC_BITS) ? IN_FRAC_BITS - STEP_FRAC_BITS : 0;

  localparam int DEL_W   = COORD_W + 1;          // end minus start
  localparam int MAG_W   = DEL_W + UP;           // scaled delta magnitude
  localparam int N_W     = DEL_W - IN_FRAC_BITS; // step count
  localparam int POS_A   = COORD_W + UP + 1;
  localparam int POS_B   = S + C + 1;
  localparam int POS_W   = (POS_A > POS_B) ? POS_A : POS_B;
  localparam int REM_W   = POS_W + 1;            // position minus end point
  localparam int INC_W   = S + 2;                // |increment| < 2 pixels
  localparam int IPART_W = POS_W - S;
  localparam int CMP_W   = (IPART_W > LIMIT_W) ? IPART_W : LIMIT_W;

  // Widen an input coordinate to the step format, truncating toward zero
  // when fraction bits are dropped.
  function automatic logic signed [POS_W-1:0] to_step(
    input logic signed [COORD_W-1:0] v
  );
    logic signed [POS_W-1:0] w;
    logic signed [POS_W-1:0] bias;
    w    = POS_W'(v) <<< UP;
    bias = v[COORD_W-1] ? POS_W'((2 ** DN) - 1) : '0;
    return (w + bias) >>> DN;
  endfunction

  // A pixel is drawn when its position is non-negative and its integer part
  // lies below both the programmed limit and the coordinate range.
  function automatic logic in_bounds(
    input logic signed [POS_W-1:0] pos,
    input logic [LIMIT_W-1:0]      lim
  );
    logic [IPART_W-1:0] ip;
    ip = pos[POS_W-1:S];
    return !pos[POS_W-1] && (CMP_W'(ip) < CMP_W'(lim)) && ((ip >> C) == '0);
  endfunction

  // True when the distance to the end point is under one whole pixel.
  function automatic logic near_end(input logic signed [REM_W-1:0] v);
    logic [REM_W-S-1:0] hi;
    hi = v[REM_W-1:S];
    return (hi == '0) || ((&hi) && (v[S-1:0] != '0));
  endfunction

  dda_pkg::state_t state_r;

  // Configuration
  logic [LIMIT_W-1:0] x_limit_r, y_limit_r;

  // Captured load item
  logic signed [COORD_W-1:0] xs_r, ys_r, xe_r, ye_r;
  logic signed [DEL_W-1:0]   dx_r, dy_r;
  logic [MAG_W-1:0]          magy_sc_r;
  logic                      neg_x_r, neg_y_r;

  // Line state
  logic signed [POS_W-1:0]   cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic signed [REM_W-1:0]   rem_x_r, rem_y_r;
  logic signed [INC_W-1:0]   inc_x_r, inc_y_r;
  logic [dda_pkg::COLOUR_W-1:0] line_colour_r;
  logic                      active_r;
  logic [N_W-1:0]            steps_left_r;

  // Output register
  logic                      out_valid_r;
  logic [C-1:0]              out_px_r, out_py_r;
  logic [dda_pkg::COLOUR_W-1:0] out_pc_r;
  logic                      out_pv_r, out_done_r;

  // Handshake
  logic in_accept, out_take, out_free;

  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != dda_pkg::S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // Step count: the larger of the truncated absolute deltas.
  logic [DEL_W-1:0] magx, magy;
  logic [N_W-1:0]   nx, ny, n_cnt;
  logic [MAG_W-1:0] magx_sc, magy_sc;

  assign magx    = dx_r[DEL_W-1] ? DEL_W'(-dx_r) : DEL_W'(dx_r);
  assign magy    = dy_r[DEL_W-1] ? DEL_W'(-dy_r) : DEL_W'(dy_r);
  assign nx      = N_W'(magx >> IN_FRAC_BITS);
  assign ny      = N_W'(magy >> IN_FRAC_BITS);
  assign n_cnt   = (nx > ny) ? nx : ny;
  assign magx_sc = (MAG_W'(magx) << UP) >> DN;
  assign magy_sc = (MAG_W'(magy) << UP) >> DN;

  // Shared divider: x increment first, then y with the same step count.
  logic                    div_start;
  logic [MAG_W-1:0]        div_dividend;
  logic [N_W-1:0]          div_divisor;
  logic [MAG_W-1:0]        div_quotient;
  dda_pkg::div_stat_t      div_stat;
  logic signed [INC_W-1:0] div_q;
  logic signed [INC_W-1:0] inc_from_div;

  assign div_start = ((state_r == dda_pkg::S_COUNT) && (n_cnt != '0)) ||
                     ((state_r == dda_pkg::S_DIVX) && div_stat.done);
  assign div_dividend = (state_r == dda_pkg::S_COUNT) ? magx_sc : magy_sc_r;
  assign div_divisor  = (state_r == dda_pkg::S_COUNT) ? n_cnt : steps_left_r;

  dda_divider #(
    .DVD_W (MAG_W),
    .DVS_W (N_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // The quotient always fits the increment width; the sign follows the delta.
  assign div_q = $signed(div_quotient[INC_W-1:0]);
  assign inc_from_div = ((state_r == dda_pkg::S_DIVX) ? neg_x_r : neg_y_r) ? -div_q : div_q;

  // Stepping datapath: one add per axis for the position and one for the
  // remaining distance, then the end test on the new distance.
  logic                    pix_ok;
  logic signed [POS_W-1:0] cur_x_nxt, cur_y_nxt;
  logic signed [REM_W-1:0] rem_x_nxt, rem_y_nxt;
  logic                    step_end;

  assign pix_ok    = in_bounds(cur_x_r, x_limit_r) && in_bounds(cur_y_r, y_limit_r);
  assign cur_x_nxt = cur_x_r + POS_W'(inc_x_r);
  assign cur_y_nxt = cur_y_r + POS_W'(inc_y_r);
  assign rem_x_nxt = rem_x_r + REM_W'(inc_x_r);
  assign rem_y_nxt = rem_y_r + REM_W'(inc_y_r);
  assign step_end  = (steps_left_r == N_W'(1)) ||
                     (near_end(rem_x_nxt) && near_end(rem_y_nxt));

  // Result selection. A load result carries no pixel; its done flag tells
  // whether the line came out empty.
  logic                         emit;
  logic [C-1:0]                 res_px, res_py;
  logic [dda_pkg::COLOUR_W-1:0] res_pc;
  logic                         res_pv, res_done;

  always_comb begin
    emit     = 1'b0;
    res_px   = '0;
    res_py   = '0;
    res_pc   = '0;
    res_pv   = 1'b0;
    res_done = 1'b1;
    case (state_r)
      dda_pkg::S_IDLE: begin
        if (in_accept && (in_action == dda_pkg::ACT_STEP)) begin
          emit = 1'b1;
          if (active_r) begin
            res_done = step_end;
            if (pix_ok) begin
              res_px = cur_x_r[S +: C];
              res_py = cur_y_r[S +: C];
              res_pc = line_colour_r;
              res_pv = 1'b1;
            end
          end
        end
      end
      dda_pkg::S_COUNT: begin
        emit = (n_cnt == '0);
      end
      dda_pkg::S_DIVY: begin
        emit     = div_stat.done;
        res_done = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Configuration registers; writes to unknown indexes fall away.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= dda_pkg::LIMIT_RESET;
      y_limit_r <= dda_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        dda_pkg::REG_X_LIMIT: x_limit_r <= cfg_wdata;
        dda_pkg::REG_Y_LIMIT: y_limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dda_pkg::S_IDLE;
      active_r     <= 1'b0;
      steps_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        dda_pkg::S_IDLE: begin
          if (in_accept) begin
            if (in_action == dda_pkg::ACT_LOAD) begin
              state_r <= dda_pkg::S_DELTA;
            end else if (active_r) begin
              steps_left_r <= steps_left_r - 1'b1;
              if (step_end) begin
                active_r <= 1'b0;
              end
            end
          end
        end
        dda_pkg::S_DELTA: begin
          state_r <= dda_pkg::S_COUNT;
        end
        dda_pkg::S_COUNT: begin
          steps_left_r <= n_cnt;
          if (n_cnt == '0) begin
            active_r <= 1'b0;
            state_r  <= dda_pkg::S_IDLE;
          end else begin
            state_r <= dda_pkg::S_DIVX;
          end
        end
        dda_pkg::S_DIVX: begin
          if (div_stat.done) begin
            state_r <= dda_pkg::S_DIVY;
          end
        end
        dda_pkg::S_DIVY: begin
          if (div_stat.done) begin
            active_r <= 1'b1;
            state_r  <= dda_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= dda_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Line datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      dda_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_action == dda_pkg::ACT_LOAD) begin
            xs_r          <= in_x_start;
            ys_r          <= in_y_start;
            xe_r          <= in_x_end;
            ye_r          <= in_y_end;
            line_colour_r <= in_colour;
          end else if (active_r) begin
            cur_x_r <= cur_x_nxt;
            cur_y_r <= cur_y_nxt;
            rem_x_r <= rem_x_nxt;
            rem_y_r <= rem_y_nxt;
          end
        end
      end
      dda_pkg::S_DELTA: begin
        dx_r     <= DEL_W'(xe_r) - DEL_W'(xs_r);
        dy_r     <= DEL_W'(ye_r) - DEL_W'(ys_r);
        cur_x_r  <= to_step(xs_r);
        cur_y_r  <= to_step(ys_r);
        goal_x_r <= to_step(xe_r);
        goal_y_r <= to_step(ye_r);
      end
      dda_pkg::S_COUNT: begin
        rem_x_r   <= REM_W'(cur_x_r) - REM_W'(goal_x_r);
        rem_y_r   <= REM_W'(cur_y_r) - REM_W'(goal_y_r);
        magy_sc_r <= magy_sc;
        neg_x_r   <= dx_r[DEL_W-1];
        neg_y_r   <= dy_r[DEL_W-1];
        if (n_cnt == '0) begin
          inc_x_r <= '0;
          inc_y_r <= '0;
        end
      end
      dda_pkg::S_DIVX: begin
        if (div_stat.done) begin
          inc_x_r <= inc_from_div;
        end
      end
      dda_pkg::S_DIVY: begin
        if (div_stat.done) begin
          inc_y_r <= inc_from_div;
        end
      end
      default: begin
      end
    endcase
  end

  // Output payload register; loaded only when a result is produced.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_px_r   <= res_px;
      out_py_r   <= res_py;
      out_pc_r   <= res_pc;
      out_pv_r   <= res_pv;
      out_done_r <= res_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_px_r;
  assign out_pixel_y      = out_py_r;
  assign out_pixel_colour = out_pc_r;
  assign out_pixel_valid  = out_pv_r;
  assign out_line_done    = out_done_r;

endmodule
